// File: design/clock_display_scan_sequencer_unit_defines.svh
// Assertion macros used by the clock display scan sequencer checker.
`ifndef CLOCK_DISPLAY_SCAN_SEQUENCER_UNIT_DEFINES_SVH
`define CLOCK_DISPLAY_SCAN_SEQUENCER_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on clk and held off during reset.
`define CDSS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("clock display scan sequencer check failed");

// Next-cycle implication, sampled on clk and held off during reset.
`define CDSS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("clock display scan sequencer check failed");

`endif

// File: design/cdss_pkg.sv
// Types, constants and segment tables of the clock display scan sequencer.
package cdss_pkg;

    localparam int IN_DATA_W  = 48;
    localparam int OUT_DATA_W = 16;

    localparam logic [6:0] SEG_ALL_OFF = 7'h7F;

    // Scan phases in display order; value 15 is never reached.
    typedef enum logic [3:0] {
        PH_DAY_TENS    = 4'd0,
        PH_DAY_ONES    = 4'd1,
        PH_MONTH_TENS  = 4'd2,
        PH_MONTH_ONES  = 4'd3,
        PH_YEAR_HIGH   = 4'd4,
        PH_YEAR_TENS   = 4'd5,
        PH_YEAR_ONES   = 4'd6,
        PH_HOUR_TENS   = 4'd7,
        PH_HOUR_ONES   = 4'd8,
        PH_MINUTE_TENS = 4'd9,
        PH_MINUTE_ONES = 4'd10,
        PH_TEMP_TENS   = 4'd11,
        PH_TEMP_ONES   = 4'd12,
        PH_WEEKDAY     = 4'd13,
        PH_LEDS        = 4'd14
    } phase_t;

    // Common line codes.
    localparam logic [3:0] COM_DAY_TENS    = 4'd0;
    localparam logic [3:0] COM_DAY_ONES    = 4'd1;
    localparam logic [3:0] COM_MONTH_ONES  = 4'd2;
    localparam logic [3:0] COM_YEAR_TENS   = 4'd3;
    localparam logic [3:0] COM_YEAR_ONES   = 4'd4;
    localparam logic [3:0] COM_HOUR_TENS   = 4'd5;
    localparam logic [3:0] COM_HOUR_ONES   = 4'd6;
    localparam logic [3:0] COM_MINUTE_TENS = 4'd7;
    localparam logic [3:0] COM_MINUTE_ONES = 4'd8;
    localparam logic [3:0] COM_TEMP_ONES   = 4'd9;
    localparam logic [3:0] COM_TEMP_TENS   = 4'd10;
    localparam logic [3:0] COM_WEEKDAY     = 4'd11;
    localparam logic [3:0] COM_LEDS        = 4'd12;
    localparam logic [3:0] COM_IDLE        = 4'd0;

    // Segment bit positions, active low.
    localparam int SEG_A = 0;
    localparam int SEG_B = 1;
    localparam int SEG_C = 2;
    localparam int SEG_D = 3;
    localparam int SEG_E = 4;
    localparam int SEG_F = 5;
    localparam int SEG_G = 6;

    localparam logic [3:0] DIGIT_BLANK = 4'd10;

    typedef logic [7:0] digit_code_array_t [0:10];
    localparam digit_code_array_t DIGIT_CODES = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90, 8'hFF
    };

    // One request as held in the input register; the year is kept modulo 100.
    typedef struct packed {
        logic [4:0] day;
        logic [3:0] month;
        logic [6:0] year_mod100;
        logic [4:0] hour;
        logic [5:0] minute;
        logic [6:0] temperature;
        logic [2:0] weekday;
    } in_item_t;

    typedef struct packed {
        logic [6:0] segment_drive;
        logic [3:0] common_select;
        logic       common_enable;
        phase_t     next_phase;
    } scan_out_t;

    // Active-low pattern of one decimal digit; anything above nine is blank.
    function automatic logic [6:0] digit_pattern(input logic [3:0] d);
        logic [3:0] idx;
        logic [7:0] code;
        idx  = (d > 4'd9) ? DIGIT_BLANK : d;
        code = DIGIT_CODES[idx];
        return code[6:0];
    endfunction

    // Tens digit of a value below 128 by reciprocal multiply (205 / 2048).
    function automatic logic [3:0] tens_of(input logic [6:0] x);
        logic [14:0] prod;
        prod = 15'(x) * 15'd205;
        return prod[14:11];
    endfunction

    // Ones digit given the value and its tens digit.
    function automatic logic [3:0] ones_of(input logic [6:0] x, input logic [3:0] tens);
        logic [6:0] t10;
        logic [6:0] diff;
        t10  = (7'(tens) << 3) + (7'(tens) << 1);
        diff = x - t10;
        return diff[3:0];
    endfunction

endpackage

// File: design/cdss_seg_decode.sv
// Segment pattern, common line and next phase for one scan phase.
module cdss_seg_decode
    import cdss_pkg::*;
(
    input  phase_t    phase,
    input  in_item_t  item,
    output scan_out_t result
);

    logic [3:0] day_tens, day_ones;
    logic [3:0] month_ones;
    logic [3:0] year_tens, year_ones;
    logic [3:0] hour_tens, hour_ones;
    logic [3:0] minute_tens, minute_ones;
    logic [3:0] temp_tens, temp_ones;
    logic [3:0] month_tens;

    always_comb
    begin
        day_tens    = tens_of(7'(item.day));
        day_ones    = ones_of(7'(item.day), day_tens);
        month_tens  = tens_of(7'(item.month));
        month_ones  = ones_of(7'(item.month), month_tens);
        year_tens   = tens_of(item.year_mod100);
        year_ones   = ones_of(item.year_mod100, year_tens);
        hour_tens   = tens_of(7'(item.hour));
        hour_ones   = ones_of(7'(item.hour), hour_tens);
        minute_tens = tens_of(7'(item.minute));
        minute_ones = ones_of(7'(item.minute), minute_tens);
        temp_tens   = tens_of(item.temperature);
        temp_ones   = ones_of(item.temperature, temp_tens);
    end

    always_comb
    begin
        result.segment_drive = SEG_ALL_OFF;
        result.common_select = COM_IDLE;
        result.common_enable = 1'b1;
        result.next_phase    = phase_t'(phase + 4'd1);
        unique case (phase)
            PH_DAY_TENS:
            begin
                // Leading zero is blanked; segment f marks a two-digit month.
                if (day_tens != 4'd0)
                    result.segment_drive = digit_pattern(day_tens);
                if (month_tens != 4'd0)
                    result.segment_drive[SEG_F] = 1'b0;
                result.common_select = COM_DAY_TENS;
            end
            PH_DAY_ONES:
            begin
                result.segment_drive = digit_pattern(day_ones);
                result.common_select = COM_DAY_ONES;
            end
            PH_MONTH_TENS, PH_YEAR_HIGH:
            begin
                result.common_enable = 1'b0;
            end
            PH_MONTH_ONES:
            begin
                result.segment_drive = digit_pattern(month_ones);
                result.common_select = COM_MONTH_ONES;
            end
            PH_YEAR_TENS:
            begin
                result.segment_drive = digit_pattern(year_tens);
                result.common_select = COM_YEAR_TENS;
            end
            PH_YEAR_ONES:
            begin
                result.segment_drive = digit_pattern(year_ones);
                result.common_select = COM_YEAR_ONES;
            end
            PH_HOUR_TENS:
            begin
                if (hour_tens != 4'd0)
                    result.segment_drive = digit_pattern(hour_tens);
                result.common_select = COM_HOUR_TENS;
            end
            PH_HOUR_ONES:
            begin
                result.segment_drive = digit_pattern(hour_ones);
                result.common_select = COM_HOUR_ONES;
            end
            PH_MINUTE_TENS:
            begin
                result.segment_drive = digit_pattern(minute_tens);
                result.common_select = COM_MINUTE_TENS;
            end
            PH_MINUTE_ONES:
            begin
                result.segment_drive = digit_pattern(minute_ones);
                result.common_select = COM_MINUTE_ONES;
            end
            PH_TEMP_TENS:
            begin
                result.segment_drive = digit_pattern(temp_tens);
                result.common_select = COM_TEMP_TENS;
            end
            PH_TEMP_ONES:
            begin
                result.segment_drive = digit_pattern(temp_ones);
                result.common_select = COM_TEMP_ONES;
            end
            PH_WEEKDAY:
            begin
                // A weekday of seven lights nothing but still enables the common.
                case (item.weekday)
                    3'd0:    result.segment_drive[SEG_G] = 1'b0;
                    3'd1:    result.segment_drive[SEG_F] = 1'b0;
                    3'd2:    result.segment_drive[SEG_A] = 1'b0;
                    3'd3:    result.segment_drive[SEG_B] = 1'b0;
                    3'd4:    result.segment_drive[SEG_C] = 1'b0;
                    3'd5:    result.segment_drive[SEG_E] = 1'b0;
                    3'd6:    result.segment_drive[SEG_D] = 1'b0;
                    default: result.segment_drive = SEG_ALL_OFF;
                endcase
                result.common_select = COM_WEEKDAY;
            end
            PH_LEDS:
            begin
                result.segment_drive[SEG_C] = 1'b0;
                result.segment_drive[SEG_D] = 1'b0;
                result.common_select = COM_LEDS;
                result.next_phase    = PH_DAY_TENS;
            end
            default:
            begin
                result.common_enable = 1'b0;
                result.next_phase    = PH_DAY_TENS;
            end
        endcase
    end

endmodule

// File: design/clock_display_scan_sequencer_unit.sv
// Top level of the clock display scan sequencer.
//
//  channel   direction  fields
//  s_axis    in         day, month, year, hour, minute, temperature, weekday
//  m_axis    out        segment_drive, common_select, common_enable
//
// One request per cycle while m_tready is high; each request is held in the input register,
// then its result in the result register. The phase sequence has 15 steps.
// Reset puts the scanner in the day tens phase and empties both registers.
// A stall on m_tready holds the result; the input register still takes one more
// request, and s_tready then follows m_tready combinationally.
module clock_display_scan_sequencer_unit
    import cdss_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // day[4:0], month[8:5], year[22:9], hour[27:23], minute[33:28],
    // temperature[40:34], weekday[43:41], zero fill[47:44]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // segment_drive[6:0], common_select[10:7], common_enable[11], zero fill[15:12]
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic       in_valid_reg;
    in_item_t   in_item_reg, in_item_next;
    phase_t     phase_reg;
    logic       out_valid_reg;
    logic [6:0] seg_reg;
    logic [3:0] sel_reg;
    logic       en_reg;
    logic       out_load;
    logic       in_load;
    scan_out_t  decoded;

    logic [13:0] year_in;
    logic [27:0] year_prod;
    logic [7:0]  year_hundreds;
    logic [14:0] year_hundreds_x100;
    logic [14:0] year_rem;

    assign out_load = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || !out_valid_reg || m_tready;
    assign in_load  = s_tvalid && s_tready;

    // Only the last two year digits are shown, so the year is reduced modulo 100
    // on the way in; 5243 / 2^19 gives the exact quotient below 16384.
    always_comb
    begin
        year_in            = s_tdata[22:9];
        year_prod          = 28'(year_in) * 28'd5243;
        year_hundreds      = year_prod[26:19];
        year_hundreds_x100 = (15'(year_hundreds) << 6) + (15'(year_hundreds) << 5)
                           + (15'(year_hundreds) << 2);
        year_rem           = 15'(year_in) - year_hundreds_x100;

        in_item_next.day         = s_tdata[4:0];
        in_item_next.month       = s_tdata[8:5];
        in_item_next.year_mod100 = year_rem[6:0];
        in_item_next.hour        = s_tdata[27:23];
        in_item_next.minute      = s_tdata[33:28];
        in_item_next.temperature = s_tdata[40:34];
        in_item_next.weekday     = s_tdata[43:41];
    end

    cdss_seg_decode u_decode (
        .phase  (phase_reg),
        .item   (in_item_reg),
        .result (decoded)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= PH_DAY_TENS;
        end
        else
        begin
            if (in_load)
                in_valid_reg <= 1'b1;
            else if (out_load)
                in_valid_reg <= 1'b0;

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                phase_reg     <= decoded.next_phase;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_load)
            in_item_reg <= in_item_next;
        if (out_load)
        begin
            seg_reg <= decoded.segment_drive;
            sel_reg <= decoded.common_select;
            en_reg  <= decoded.common_enable;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, en_reg, sel_reg, seg_reg};

endmodule

// File: design/cdss_checker.sv
// Port-level checks of the clock display scan sequencer, bound to the top level.
`include "clock_display_scan_sequencer_unit_defines.svh"

module cdss_checker
    import cdss_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_tready,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata
);

    // A request that waits on the output side stays offered.
    `CDSS_ASSERT_NEXT(a_out_held, m_tvalid && !m_tready, m_tvalid)

    // When the sink is ready the block is always ready for a new request.
    `CDSS_ASSERT_NOW(a_ready_when_drained, m_tready, s_tready)

    // An idle phase shows nothing and selects common zero.
    `CDSS_ASSERT_NOW(a_idle_blank, m_tvalid && !m_tdata[11],
        (m_tdata[6:0] == SEG_ALL_OFF) && (m_tdata[10:7] == COM_IDLE))

    // Only the thirteen common codes appear.
    `CDSS_ASSERT_NOW(a_select_range, m_tvalid,
        (m_tdata[10:7] <= COM_LEDS) && (m_tdata[15:12] == 4'd0))

endmodule

bind clock_display_scan_sequencer_unit cdss_checker u_cdss_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
